// ----- hw/rtl/hfx_pkg.sv -----
// shared types and constants of the header/footer frame extractor
package hfx_pkg;

    localparam int BYTE_W        = 8;
    localparam int IDX_W         = 6;
    localparam int CFG_DATA_W    = 32;
    localparam int LAYOUT_W      = 27;
    localparam int LEN_FIELD_W   = 6;
    localparam int PAT_REG_BYTES = 4;

    // register kinds within one type's group of registers
    localparam int REGS_PER_TYPE = 3;
    localparam int REG_HDR       = 0;
    localparam int REG_FTR       = 1;
    localparam int REG_LAYOUT    = 2;

    // frame buffer banks, one per queued frame
    localparam int NUM_BANKS = 2;
    localparam int BANK_W    = 1;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HDR     = 3'd1,
        PH_DATA    = 3'd2,
        PH_FTR     = 3'd3,
        PH_FTR_CHK = 3'd4
    } t_phase;

    typedef struct packed {
        logic                   enable;
        logic [LEN_FIELD_W-1:0] max_data;
        logic [LEN_FIELD_W-1:0] min_data;
        logic [2:0]             ftr_len;
        logic [2:0]             hdr_len;
        logic [BYTE_W-1:0]      code;
    } t_layout;

endpackage

// ----- hw/rtl/header_footer_frame_extractor_top.sv -----
// top level of the header/footer delimited frame extractor
// Usage: received bytes enter on i_valid / o_stall with i_rx_byte, one beat per cycle
// while o_stall is low. Each accepted byte is matched against the header, data and
// footer rules of up to NUM_TYPES frame types and stored in one of two buffer banks.
// When a footer completes, the whole frame (header through footer) leaves on
// o_valid / i_stall, one beat per byte with the type code, byte index and a last mark.
// A frame's descriptor enters the queue at the edge that accepts its final footer byte;
// its bytes then pass through the registered buffer ram read into the output register.
// A byte is read only once the previous one has landed there, so beats never abut.
// o_stall rises only while two completed frames occupy both banks; it falls as soon
// as the older frame has been read out of its bank.
// A stalled output beat holds its payload; input keeps flowing into the free bank.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and 32-bit data;
// o_cfg_ready is always high and writes take effect on the next byte.
// Reset (synchronous, active low) clears all type registers, which disables every
// type, empties the queue and returns the parser to header hunting. No clearing
// pass is needed: only written buffer entries are ever read.
module header_footer_frame_extractor_top #(
    parameter int BUFFER_DEPTH      = 64,
    parameter int MAX_PATTERN_BYTES = 4,
    parameter int NUM_TYPES         = 2
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [7:0]                              i_rx_byte,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [$clog2(3*NUM_TYPES)-1:0]          i_cfg_index,
    input  logic [31:0]                             i_cfg_data,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [7:0]                              o_frame_byte,
    output logic [7:0]                              o_frame_type,
    output logic [5:0]                              o_byte_index,
    output logic                                    o_last_byte
);

    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int FCW   = $clog2(BUFFER_DEPTH + 1);
    localparam int RAW   = hfx_pkg::BANK_W + AW;
    localparam int DESCW = FCW + hfx_pkg::BYTE_W;

    logic                       ram_we, ram_re;
    logic [RAW-1:0]             ram_waddr, ram_raddr;
    logic [hfx_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;
    logic                       desc_push, q_pop, q_empty, q_full;
    logic [DESCW-1:0]           desc_in, desc_head;

    assign o_cfg_ready = 1'b1;

    hfx_front #(
        .BUFFER_DEPTH      (BUFFER_DEPTH),
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .NUM_TYPES         (NUM_TYPES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_rx_byte   (i_rx_byte),
        .o_stall     (o_stall),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_desc_push (desc_push),
        .o_desc_data (desc_in),
        .i_q_full    (q_full)
    );

    hfx_ram #(
        .WIDTH (hfx_pkg::BYTE_W),
        .DEPTH (hfx_pkg::NUM_BANKS * (1 << AW))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hfx_queue #(
        .WIDTH (DESCW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_data  (desc_in),
        .i_pop   (q_pop),
        .o_data  (desc_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    hfx_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_data     (desc_head),
        .o_q_pop      (q_pop),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_frame_type (o_frame_type),
        .o_byte_index (o_byte_index),
        .o_last_byte  (o_last_byte)
    );

endmodule

// ----- hw/rtl/hfx_ram.sv -----
// generic single write port, single read port ram with registered read
module hfx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/hfx_front.sv -----
// front end: configuration registers, frame parser and buffer writes
module hfx_front #(
    parameter int BUFFER_DEPTH      = 64,
    parameter int MAX_PATTERN_BYTES = 4,
    parameter int NUM_TYPES         = 2
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    input  logic [hfx_pkg::BYTE_W-1:0]                      i_rx_byte,
    output logic                                            o_stall,
    input  logic                                            i_cfg_valid,
    input  logic [$clog2(hfx_pkg::REGS_PER_TYPE*NUM_TYPES)-1:0] i_cfg_index,
    input  logic [hfx_pkg::CFG_DATA_W-1:0]                  i_cfg_data,
    output logic                                            o_ram_we,
    output logic [hfx_pkg::BANK_W+$clog2(BUFFER_DEPTH)-1:0] o_ram_waddr,
    output logic [hfx_pkg::BYTE_W-1:0]                      o_ram_wdata,
    output logic                                            o_desc_push,
    output logic [$clog2(BUFFER_DEPTH+1)+hfx_pkg::BYTE_W-1:0] o_desc_data,
    input  logic                                            i_q_full
);

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int FCW = $clog2(BUFFER_DEPTH + 1);
    localparam int PW  = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int TW  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int CIW = $clog2(hfx_pkg::REGS_PER_TYPE * NUM_TYPES);
    localparam int CW  = (FCW > hfx_pkg::LEN_FIELD_W) ? FCW : hfx_pkg::LEN_FIELD_W;

    logic [hfx_pkg::CFG_DATA_W-1:0] r_hdr [NUM_TYPES];
    logic [hfx_pkg::CFG_DATA_W-1:0] r_ftr [NUM_TYPES];
    hfx_pkg::t_layout               r_lay [NUM_TYPES];

    hfx_pkg::t_phase          r_phase, n_phase;
    logic [FCW-1:0]           r_fill, n_fill;
    logic [PW-1:0]            r_dstart, n_dstart;
    logic [FCW-1:0]           r_fstart, n_fstart;
    logic [TW-1:0]            r_type, n_type;
    logic [hfx_pkg::BANK_W-1:0] r_bank, n_bank;

    logic                     acc;
    logic                     hit;
    logic [TW-1:0]            hit_t;
    hfx_pkg::t_layout         cur_lay;
    logic [hfx_pkg::CFG_DATA_W-1:0] cur_hdr, cur_ftr;
    logic [FCW-1:0]           nf, d_len_new, d_len_old, ftr_pos, ftr_got;
    logic [FCW-1:0]           hlen, flen, hit_hlen;
    logic [CW-1:0]            mx, mn;
    logic                     can_push, do_restart, do_emit;

    function automatic logic [FCW-1:0] clamp_len(input logic [2:0] v);
        logic [FCW-1:0] r;
        if (v == 3'd0) begin
            r = FCW'(1);
        end else if (FCW'(v) > FCW'(MAX_PATTERN_BYTES)) begin
            r = FCW'(MAX_PATTERN_BYTES);
        end else begin
            r = FCW'(v);
        end
        return r;
    endfunction

    // a pattern byte exists below the pattern limit; bytes past the register read zero
    function automatic logic pat_match(input logic [hfx_pkg::CFG_DATA_W-1:0] pat,
                                       input logic [FCW-1:0] pos,
                                       input logic [hfx_pkg::BYTE_W-1:0] b);
        logic [hfx_pkg::BYTE_W-1:0] pb;
        pb = '0;
        if (pos < FCW'(hfx_pkg::PAT_REG_BYTES)) begin
            unique case (pos[1:0])
                2'd0:    pb = pat[7:0];
                2'd1:    pb = pat[15:8];
                2'd2:    pb = pat[23:16];
                default: pb = pat[31:24];
            endcase
        end
        return (pos < FCW'(MAX_PATTERN_BYTES)) && (pb == b);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TYPES; t++) begin
                r_hdr[t] <= '0;
                r_ftr[t] <= '0;
                r_lay[t] <= '0;
            end
        end else if (i_cfg_valid) begin
            for (int t = 0; t < NUM_TYPES; t++) begin
                if (i_cfg_index == CIW'(hfx_pkg::REGS_PER_TYPE * t + hfx_pkg::REG_HDR)) begin
                    r_hdr[t] <= i_cfg_data;
                end
                if (i_cfg_index == CIW'(hfx_pkg::REGS_PER_TYPE * t + hfx_pkg::REG_FTR)) begin
                    r_ftr[t] <= i_cfg_data;
                end
                if (i_cfg_index == CIW'(hfx_pkg::REGS_PER_TYPE * t + hfx_pkg::REG_LAYOUT)) begin
                    r_lay[t] <= hfx_pkg::t_layout'(i_cfg_data[hfx_pkg::LAYOUT_W-1:0]);
                end
            end
        end
    end

    // lowest numbered enabled type wins on the first header byte
    always_comb begin
        hit   = 1'b0;
        hit_t = '0;
        for (int t = NUM_TYPES - 1; t >= 0; t--) begin
            if (r_lay[t].enable && (r_hdr[t][7:0] == i_rx_byte)) begin
                hit   = 1'b1;
                hit_t = TW'(t);
            end
        end
    end

    assign acc      = i_valid && !o_stall;
    assign o_stall  = i_q_full;
    assign cur_lay  = r_lay[r_type];
    assign cur_hdr  = r_hdr[r_type];
    assign cur_ftr  = r_ftr[r_type];
    assign nf       = r_fill + FCW'(1);
    assign can_push = r_fill < FCW'(BUFFER_DEPTH);
    assign d_len_new = nf - FCW'(r_dstart);
    assign d_len_old = r_fill - FCW'(r_dstart);
    assign ftr_pos  = r_fill - r_fstart;
    assign ftr_got  = nf - r_fstart;
    assign hlen     = clamp_len(cur_lay.hdr_len);
    assign flen     = clamp_len(cur_lay.ftr_len);
    assign hit_hlen = clamp_len(r_lay[hit_t].hdr_len);
    assign mx       = CW'(cur_lay.max_data);
    assign mn       = CW'(cur_lay.min_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hfx_pkg::PH_HUNT;
            r_fill   <= '0;
            r_dstart <= '0;
            r_fstart <= '0;
            r_type   <= '0;
            r_bank   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_fill   <= n_fill;
            r_dstart <= n_dstart;
            r_fstart <= n_fstart;
            r_type   <= n_type;
            r_bank   <= n_bank;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_fill     = r_fill;
        n_dstart   = r_dstart;
        n_fstart   = r_fstart;
        n_type     = r_type;
        n_bank     = r_bank;
        o_ram_we   = 1'b0;
        do_restart = 1'b0;
        do_emit    = 1'b0;

        if (acc) begin
            unique case (r_phase)
                hfx_pkg::PH_HUNT: begin
                    if (hit && can_push) begin
                        o_ram_we = 1'b1;
                        n_fill   = nf;
                        n_type   = hit_t;
                        if (hit_hlen <= FCW'(1)) begin
                            n_dstart = PW'(nf);
                            n_phase  = hfx_pkg::PH_DATA;
                        end else begin
                            n_phase  = hfx_pkg::PH_HDR;
                        end
                    end else begin
                        do_restart = 1'b1;
                    end
                end
                hfx_pkg::PH_HDR: begin
                    if (pat_match(cur_hdr, r_fill, i_rx_byte) && can_push) begin
                        o_ram_we = 1'b1;
                        n_fill   = nf;
                        if (nf >= hlen) begin
                            n_dstart = PW'(nf);
                            n_phase  = hfx_pkg::PH_DATA;
                        end
                    end else begin
                        do_restart = 1'b1;
                    end
                end
                hfx_pkg::PH_DATA: begin
                    if (!can_push || (CW'(d_len_new) > mx)) begin
                        do_restart = 1'b1;
                    end else begin
                        o_ram_we = 1'b1;
                        n_fill   = nf;
                        if ((CW'(d_len_new) == mx) || (CW'(d_len_new) >= mn)) begin
                            n_phase  = hfx_pkg::PH_FTR;
                            n_fstart = nf;
                        end
                    end
                end
                hfx_pkg::PH_FTR: begin
                    if (cur_ftr[7:0] == i_rx_byte) begin
                        if (!can_push) begin
                            do_restart = 1'b1;
                        end else begin
                            o_ram_we = 1'b1;
                            n_fill   = nf;
                            if (flen <= FCW'(1)) begin
                                do_emit = 1'b1;
                            end else begin
                                n_phase = hfx_pkg::PH_FTR_CHK;
                            end
                        end
                    end else if ((CW'(d_len_old) > mx) || !can_push) begin
                        do_restart = 1'b1;
                    end else begin
                        o_ram_we = 1'b1;
                        n_fill   = nf;
                        n_fstart = nf;
                    end
                end
                hfx_pkg::PH_FTR_CHK: begin
                    if (!can_push) begin
                        do_restart = 1'b1;
                    end else begin
                        o_ram_we = 1'b1;
                        n_fill   = nf;
                        if (pat_match(cur_ftr, ftr_pos, i_rx_byte)) begin
                            if (ftr_got >= flen) begin
                                do_emit = 1'b1;
                            end
                        end else begin
                            n_phase = hfx_pkg::PH_DATA;
                        end
                    end
                end
                default: begin
                    do_restart = 1'b1;
                end
            endcase
        end

        // after a completed frame, writing moves to the other bank
        if (do_emit) begin
            n_bank     = r_bank + hfx_pkg::BANK_W'(1);
            do_restart = 1'b1;
        end
        if (do_restart) begin
            n_phase  = hfx_pkg::PH_HUNT;
            n_fill   = '0;
            n_dstart = '0;
            n_fstart = '0;
            n_type   = '0;
        end
    end

    assign o_ram_waddr = {r_bank, r_fill[AW-1:0]};
    assign o_ram_wdata = i_rx_byte;
    assign o_desc_push = do_emit;
    assign o_desc_data = {nf, cur_lay.code};

endmodule

// ----- hw/rtl/hfx_queue.sv -----
// short queue of completed frame descriptors between front and back
module hfx_queue #(
    parameter int WIDTH = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTW = hfx_pkg::BANK_W;

    logic [WIDTH-1:0] r_mem [hfx_pkg::NUM_BANKS];
    logic [PTW-1:0]   r_wptr, r_rptr;
    logic [PTW:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PTW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PTW+1)'(1);
            end
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PTW+1)'(hfx_pkg::NUM_BANKS));

endmodule

// ----- hw/rtl/hfx_back.sv -----
// back end: reads a completed frame out of its bank and presents it beat by beat
module hfx_back #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_q_empty,
    input  logic [$clog2(BUFFER_DEPTH+1)+hfx_pkg::BYTE_W-1:0] i_q_data,
    output logic                                            o_q_pop,
    output logic                                            o_ram_re,
    output logic [hfx_pkg::BANK_W+$clog2(BUFFER_DEPTH)-1:0] o_ram_raddr,
    input  logic [hfx_pkg::BYTE_W-1:0]                      i_ram_rdata,
    output logic                                            o_valid,
    input  logic                                            i_stall,
    output logic [hfx_pkg::BYTE_W-1:0]                      o_frame_byte,
    output logic [hfx_pkg::BYTE_W-1:0]                      o_frame_type,
    output logic [hfx_pkg::IDX_W-1:0]                       o_byte_index,
    output logic                                            o_last_byte
);

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int FCW = $clog2(BUFFER_DEPTH + 1);

    logic [FCW-1:0]             head_len;
    logic [hfx_pkg::BYTE_W-1:0] head_code;
    logic                       issue, issue_last;

    logic [AW-1:0]              r_idx;
    logic [hfx_pkg::BANK_W-1:0] r_bank;
    logic                       r_rd_pend;
    logic [AW-1:0]              r_pend_idx;
    logic                       r_pend_last;
    logic [hfx_pkg::BYTE_W-1:0] r_pend_code;
    logic                       r_o_valid;
    logic [hfx_pkg::BYTE_W-1:0] r_frame_byte;
    logic [hfx_pkg::BYTE_W-1:0] r_frame_type;
    logic [hfx_pkg::IDX_W-1:0]  r_byte_index;
    logic                       r_last_byte;

    assign head_len  = i_q_data[FCW+hfx_pkg::BYTE_W-1:hfx_pkg::BYTE_W];
    assign head_code = i_q_data[hfx_pkg::BYTE_W-1:0];

    // read only when the output register is free by the time the data lands
    assign issue      = !i_q_empty && !r_rd_pend && (!r_o_valid || !i_stall);
    assign issue_last = (FCW'(r_idx) + FCW'(1)) == head_len;

    assign o_ram_re    = issue;
    assign o_ram_raddr = {r_bank, r_idx};
    // the bank is released once its last byte has been read
    assign o_q_pop     = issue && issue_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_bank    <= '0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_pend <= issue;
            if (issue) begin
                if (issue_last) begin
                    r_idx  <= '0;
                    r_bank <= r_bank + hfx_pkg::BANK_W'(1);
                end else begin
                    r_idx  <= r_idx + AW'(1);
                end
            end
            priority if (r_rd_pend) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end else begin
                r_o_valid <= r_o_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_idx  <= r_idx;
            r_pend_last <= issue_last;
            r_pend_code <= head_code;
        end
        if (r_rd_pend) begin
            r_frame_byte <= i_ram_rdata;
            r_frame_type <= r_pend_code;
            r_byte_index <= hfx_pkg::IDX_W'(r_pend_idx);
            r_last_byte  <= r_pend_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_frame_byte = r_frame_byte;
    assign o_frame_type = r_frame_type;
    assign o_byte_index = r_byte_index;
    assign o_last_byte  = r_last_byte;

endmodule

// ----- hw/rtl/hfx_checker.sv -----
// port level checks of the frame extractor, bound to the top level
module hfx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_frame_byte,
    input logic [7:0] o_frame_type,
    input logic [5:0] o_byte_index,
    input logic       o_last_byte
);

    // a held beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid &&
            $stable({o_frame_byte, o_frame_type, o_byte_index, o_last_byte}))
        else $error("output beat changed while stalled");

    // reset leaves no output beat and no input backpressure
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall active after reset");

    // a taken beat is always followed by a bubble while the next byte is read
    a_beat_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("back-to-back output beats");

endmodule

bind header_footer_frame_extractor_top hfx_checker u_hfx_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_frame_byte (o_frame_byte),
    .o_frame_type (o_frame_type),
    .o_byte_index (o_byte_index),
    .o_last_byte  (o_last_byte)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the header/footer frame extractor
module testbench;

    localparam int NTYPES          = 2;
    localparam int BUF_DEPTH       = 64;
    localparam int MAX_PAT         = 4;
    localparam int CFG_IDX_W       = $clog2(hfx_pkg::REGS_PER_TYPE * NTYPES);
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int RANDOM_ITEMS    = 250;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int MAX_REPORTS     = 10;

    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;

    localparam int FLAW_NONE = 0;
    localparam int FLAW_HDR  = 1;
    localparam int FLAW_FTR  = 2;

    localparam int PROF_SMALL   = 0;
    localparam int PROF_LARGE   = 1;
    localparam int PROF_EXTREME = 2;

    typedef struct packed {
        logic [hfx_pkg::BYTE_W-1:0] data;
        logic [hfx_pkg::BYTE_W-1:0] code;
        logic [hfx_pkg::IDX_W-1:0]  index;
        logic                       last;
    } t_beat;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic [7:0]            i_rx_byte   = '0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [31:0]           i_cfg_data  = '0;
    logic                  i_stall     = 1'b0;
    logic                  o_stall;
    logic                  o_cfg_ready;
    logic                  o_valid;
    logic [7:0]            o_frame_byte;
    logic [7:0]            o_frame_type;
    logic [5:0]            o_byte_index;
    logic                  o_last_byte;

    header_footer_frame_extractor_top #(
        .BUFFER_DEPTH      (BUF_DEPTH),
        .MAX_PATTERN_BYTES (MAX_PAT),
        .NUM_TYPES         (NTYPES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_frame_type (o_frame_type),
        .o_byte_index (o_byte_index),
        .o_last_byte  (o_last_byte)
    );

    always #5 i_clk = ~i_clk;

    // parser copy: type registers and frame state
    logic [31:0]      hdr_cfg [NTYPES];
    logic [31:0]      ftr_cfg [NTYPES];
    hfx_pkg::t_layout lay_cfg [NTYPES];
    logic [7:0]       frame_mem [BUF_DEPTH];
    hfx_pkg::t_phase  phase_q;
    int unsigned      fill_cnt;
    int unsigned      data_at;
    int unsigned      footer_at;
    int               cur_type;

    t_beat        frame_beats_q [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;

    // stimulus control
    int           stall_mode  = STALL_RANDOM;
    int           hold_cycles = 0;
    int           stall_tick  = 0;
    bit           gaps_on     = 1'b1;
    int           burst_left  = 4;

    function automatic void clear_parser();
        phase_q   = hfx_pkg::PH_HUNT;
        fill_cnt  = 0;
        data_at   = 0;
        footer_at = 0;
        cur_type  = 0;
    endfunction

    function automatic void reset_model();
        for (int t = 0; t < NTYPES; t++) begin
            hdr_cfg[t] = '0;
            ftr_cfg[t] = '0;
            lay_cfg[t] = '0;
        end
        clear_parser();
    endfunction

    function automatic void apply_reg(input int idx, input logic [31:0] data);
        int t;
        if (idx >= hfx_pkg::REGS_PER_TYPE * NTYPES) return;
        t = idx / hfx_pkg::REGS_PER_TYPE;
        case (idx % hfx_pkg::REGS_PER_TYPE)
            hfx_pkg::REG_HDR:    hdr_cfg[t] = data;
            hfx_pkg::REG_FTR:    ftr_cfg[t] = data;
            hfx_pkg::REG_LAYOUT: lay_cfg[t] = hfx_pkg::t_layout'(data[hfx_pkg::LAYOUT_W-1:0]);
            default: ;
        endcase
    endfunction

    function automatic int pattern_len(input logic [2:0] v);
        if (v == 0) return 1;
        if (v > MAX_PAT) return MAX_PAT;
        return int'(v);
    endfunction

    // positions past the register count as a mismatch
    function automatic bit pattern_hit(input logic [31:0] pat, input int unsigned pos,
                                       input logic [7:0] b);
        if (pos >= MAX_PAT) return 1'b0;
        return pat[8*pos +: 8] == b;
    endfunction

    function automatic bit store_byte(input logic [7:0] b);
        if (fill_cnt >= BUF_DEPTH) return 1'b0;
        frame_mem[fill_cnt] = b;
        fill_cnt++;
        return 1'b1;
    endfunction

    function automatic void release_frame();
        t_beat beat;
        for (int unsigned i = 0; i < fill_cnt; i++) begin
            beat.data  = frame_mem[i];
            beat.code  = lay_cfg[cur_type].code;
            beat.index = i[hfx_pkg::IDX_W-1:0];
            beat.last  = (i + 1 == fill_cnt);
            frame_beats_q.insert(frame_beats_q.size(), beat);
        end
        clear_parser();
    endfunction

    function automatic void parser_step(input logic [7:0] b);
        bit          found;
        int          sel;
        int unsigned mn;
        int unsigned mx;
        int unsigned len;
        int unsigned pos;
        found = 1'b0;
        sel   = 0;
        mn    = int'(lay_cfg[cur_type].min_data);
        mx    = int'(lay_cfg[cur_type].max_data);
        case (phase_q)
            hfx_pkg::PH_HUNT: begin
                // lowest enabled type wins
                for (int i = 0; i < NTYPES; i++) begin
                    if (!found && lay_cfg[i].enable && hdr_cfg[i][7:0] == b) begin
                        found = 1'b1;
                        sel   = i;
                    end
                end
                if (!found || !store_byte(b)) begin
                    clear_parser();
                end else begin
                    cur_type = sel;
                    if (pattern_len(lay_cfg[sel].hdr_len) <= 1) begin
                        data_at = fill_cnt;
                        phase_q = hfx_pkg::PH_DATA;
                    end else begin
                        phase_q = hfx_pkg::PH_HDR;
                    end
                end
            end
            hfx_pkg::PH_HDR: begin
                if (pattern_hit(hdr_cfg[cur_type], fill_cnt, b) && store_byte(b)) begin
                    if (fill_cnt >= pattern_len(lay_cfg[cur_type].hdr_len)) begin
                        data_at = fill_cnt;
                        phase_q = hfx_pkg::PH_DATA;
                    end
                end else begin
                    clear_parser();
                end
            end
            hfx_pkg::PH_DATA: begin
                if (!store_byte(b)) begin
                    clear_parser();
                end else begin
                    len = fill_cnt - data_at;
                    if (len == mx || (len < mx && len >= mn)) begin
                        phase_q   = hfx_pkg::PH_FTR;
                        footer_at = fill_cnt;
                    end else if (len > mx) begin
                        clear_parser();
                    end
                end
            end
            hfx_pkg::PH_FTR: begin
                if (pattern_hit(ftr_cfg[cur_type], 0, b)) begin
                    if (!store_byte(b)) clear_parser();
                    else if (pattern_len(lay_cfg[cur_type].ftr_len) <= 1) release_frame();
                    else phase_q = hfx_pkg::PH_FTR_CHK;
                end else if (fill_cnt - data_at > mx) begin
                    clear_parser();
                end else if (!store_byte(b)) begin
                    clear_parser();
                end else begin
                    footer_at = fill_cnt;
                end
            end
            hfx_pkg::PH_FTR_CHK: begin
                pos = fill_cnt - footer_at;
                if (!store_byte(b)) begin
                    clear_parser();
                end else if (pattern_hit(ftr_cfg[cur_type], pos, b)) begin
                    if (fill_cnt - footer_at >= pattern_len(lay_cfg[cur_type].ftr_len))
                        release_frame();
                end else begin
                    // footer broken: back to data collection
                    phase_q = hfx_pkg::PH_DATA;
                end
            end
            default: clear_parser();
        endcase
    endfunction

    // receiver stall pattern and long hold-off
    always @(negedge i_clk) begin
        stall_tick++;
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles--;
        end else begin
            case (stall_mode)
                STALL_NONE:     i_stall <= 1'b0;
                STALL_RANDOM:   i_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: i_stall <= ((stall_tick % 9) < 4);
                default:        i_stall <= 1'b0;
            endcase
        end
    end

    // output beat checker
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_frame_byte, o_frame_type, o_byte_index, o_last_byte};
            if (frame_beats_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected beat: byte %h type %h index %0d last %b",
                             got.data, got.code, got.index, got.last);
            end else begin
                want = frame_beats_q.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"beat mismatch: expected byte %h type %h index %0d ",
                                  "last %b, got byte %h type %h index %0d last %b"},
                                 want.data, want.code, want.index, want.last,
                                 got.data, got.code, got.index, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        parser_step(b);
        @(negedge i_clk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // let every expected beat arrive, then let the parser settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (frame_beats_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input int idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx[CFG_IDX_W-1:0];
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_type(input int t, input logic [31:0] hdr, input logic [31:0] ftr,
                                input logic [31:0] layout);
        write_reg(hfx_pkg::REGS_PER_TYPE * t + hfx_pkg::REG_HDR, hdr);
        write_reg(hfx_pkg::REGS_PER_TYPE * t + hfx_pkg::REG_FTR, ftr);
        write_reg(hfx_pkg::REGS_PER_TYPE * t + hfx_pkg::REG_LAYOUT, layout);
    endtask

    function automatic logic [31:0] make_layout(input logic [7:0] code, input int hlen,
                                                input int flen, input int mn, input int mx,
                                                input bit en);
        hfx_pkg::t_layout lay;
        lay.code     = code;
        lay.hdr_len  = hlen[2:0];
        lay.ftr_len  = flen[2:0];
        lay.min_data = mn[hfx_pkg::LEN_FIELD_W-1:0];
        lay.max_data = mx[hfx_pkg::LEN_FIELD_W-1:0];
        lay.enable   = en;
        return {{(32 - hfx_pkg::LAYOUT_W){1'b0}}, lay};
    endfunction

    task automatic send_frame(input int t, input int nd, input int flaw, inout int sent);
        int          hl;
        int          fl;
        int          pos;
        logic [31:0] hp;
        logic [31:0] fp;
        logic [7:0]  flip;
        hl   = pattern_len(lay_cfg[t].hdr_len);
        fl   = pattern_len(lay_cfg[t].ftr_len);
        hp   = hdr_cfg[t];
        fp   = ftr_cfg[t];
        flip = 8'h01 << $urandom_range(0, 7);
        if (flaw == FLAW_HDR) begin
            pos = $urandom_range(0, hl - 1);
            hp[8*pos +: 8] = hp[8*pos +: 8] ^ flip;
        end
        if (flaw == FLAW_FTR) begin
            pos = $urandom_range(0, fl - 1);
            fp[8*pos +: 8] = fp[8*pos +: 8] ^ flip;
        end
        for (int i = 0; i < hl; i++) send_byte(hp[8*i +: 8]);
        repeat (nd) send_byte(8'($urandom));
        for (int i = 0; i < fl; i++) send_byte(fp[8*i +: 8]);
        sent += hl + nd + fl;
    endtask

    task automatic send_random_frame(inout int sent);
        int kind;
        int t;
        int mn;
        int mx;
        int lo;
        int nd;
        kind = $urandom_range(0, 9);
        t    = $urandom_range(0, NTYPES - 1);
        if (!lay_cfg[t].enable) t = (t + 1) % NTYPES;
        if (kind == 9 || !lay_cfg[t].enable) begin
            repeat ($urandom_range(1, 6)) begin
                send_byte(8'($urandom));
                sent++;
            end
        end else begin
            mn = int'(lay_cfg[t].min_data);
            mx = int'(lay_cfg[t].max_data);
            lo = (mn < 1) ? 1 : mn;
            nd = (lo > mx) ? mx : $urandom_range(lo, mx);
            if (nd < 1) nd = 1;
            if (kind == 8) nd = mx + 1 + $urandom_range(0, 2);
            send_frame(t, nd, (kind == 7) ? FLAW_HDR : (kind == 6) ? FLAW_FTR : FLAW_NONE,
                       sent);
        end
    endtask

    task automatic setup_profile(input int profile);
        logic [31:0] hdr;
        case (profile)
            PROF_LARGE: begin
                for (int t = 0; t < NTYPES; t++)
                    program_type(t, $urandom, $urandom,
                                 make_layout(8'($urandom), 4, 4, 56, 63, 1));
            end
            PROF_EXTREME: begin
                program_type(0, 32'h0000_0000, 32'hFFFF_FFFF, make_layout(8'h00, 4, 4, 0, 63, 1));
                // all-ones layout: every frame of this type overflows the buffer
                program_type(1, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
            end
            default: begin
                for (int t = 0; t < NTYPES; t++)
                    program_type(t, $urandom, $urandom,
                                 make_layout(8'($urandom), $urandom_range(0, 7),
                                             $urandom_range(0, 7), $urandom_range(0, 4),
                                             $urandom_range(0, 8), $urandom_range(0, 5) != 0));
                // shared first header byte now and then
                if ($urandom_range(0, 2) == 0) begin
                    hdr = $urandom;
                    hdr[7:0] = hdr_cfg[0][7:0];
                    write_reg(hfx_pkg::REGS_PER_TYPE * 1 + hfx_pkg::REG_HDR, hdr);
                end
            end
        endcase
    endtask

    task automatic test_disabled_types();
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_type_priority();
        wait_idle();
        program_type(0, 32'h0000_0055, 32'h0000_00AA, make_layout(8'h11, 0, 0, 1, 2, 1));
        program_type(1, 32'h0000_6655, 32'h0000_00AA, make_layout(8'h22, 2, 1, 1, 2, 1));
        send_byte(8'h55);
        send_byte(8'h01);
        send_byte(8'hAA);
    endtask

    task automatic test_min_above_max();
        wait_idle();
        write_reg(hfx_pkg::REGS_PER_TYPE * 0 + hfx_pkg::REG_LAYOUT,
                  make_layout(8'h33, 1, 1, 5, 2, 1));
        send_byte(8'h55);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'hAA);
    endtask

    task automatic test_long_patterns();
        wait_idle();
        write_reg(hfx_pkg::REGS_PER_TYPE * 0 + hfx_pkg::REG_LAYOUT,
                  make_layout(8'h00, 1, 1, 1, 2, 0));
        program_type(1, 32'h4433_2211, 32'h0000_BBAA, make_layout(8'h5C, 7, 2, 1, 8, 1));
        // broken footer goes back to data, then a good footer closes the frame
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'h44);
        send_byte(8'h07);
        send_byte(8'hAA);
        send_byte(8'h00);
        send_byte(8'h05);
        send_byte(8'hAA);
        send_byte(8'hBB);
        // header mismatch
        send_byte(8'h11);
        send_byte(8'h99);
    endtask

    task automatic test_live_rewrite();
        wait_idle();
        send_byte(8'h11);
        send_byte(8'h22);
        // header changed while the parser sits inside it
        wait_idle();
        write_reg(hfx_pkg::REGS_PER_TYPE * 1 + hfx_pkg::REG_HDR, 32'h4477_2211);
        send_byte(8'h77);
        send_byte(8'h44);
        send_byte(8'h05);
        send_byte(8'hAA);
        send_byte(8'hBB);
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        program_type(0, 32'h0000_00C3, 32'h0000_003C, make_layout(8'h7E, 1, 1, 1, 3, 1));
        write_reg(hfx_pkg::REGS_PER_TYPE * 1 + hfx_pkg::REG_LAYOUT, 32'h0000_0000);
        gaps_on     = 1'b0;
        hold_cycles = HOLD_OFF_CYCLES;
        repeat (10) begin
            send_byte(8'hC3);
            send_byte(8'($urandom));
            send_byte(8'h3C);
        end
        gaps_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int sent;
        int budget;
        int round;
        int profile;
        sent  = 0;
        round = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            profile = (round == 1 || round == 5) ? PROF_LARGE :
                      (round == 3) ? PROF_EXTREME : PROF_SMALL;
            setup_profile(profile);
            // indexes past the last register are ignored
            if (round == 2) begin
                write_reg(hfx_pkg::REGS_PER_TYPE * NTYPES, $urandom);
                write_reg(hfx_pkg::REGS_PER_TYPE * NTYPES + 1, $urandom);
            end
            stall_mode = round % 3;
            gaps_on    = (round % 4 != 2);
            if (profile == PROF_LARGE) begin
                // one full 64-byte frame, one that overflows the buffer
                send_frame(0, 56, FLAW_NONE, sent);
                send_frame(1, $urandom_range(57, 63), FLAW_NONE, sent);
            end else begin
                budget = sent + 40;
                while (sent < budget) send_random_frame(sent);
            end
            round++;
        end
        stall_mode = STALL_RANDOM;
        gaps_on    = 1'b1;
    endtask

    initial begin
        reset_model();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_disabled_types();
        test_type_priority();
        test_min_above_max();
        test_long_patterns();
        test_live_rewrite();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0 && frame_beats_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- header_footer_frame_extractor_top.f -----
hw/rtl/hfx_pkg.sv
hw/rtl/hfx_ram.sv
hw/rtl/hfx_front.sv
hw/rtl/hfx_queue.sv
hw/rtl/hfx_back.sv
hw/rtl/header_footer_frame_extractor_top.sv
hw/rtl/hfx_checker.sv
sim/testbench.sv
